// ----- design/smcc_pkg.sv -----
`default_nettype none
package smcc_pkg;

   // Table geometry. TABLE_ENTRIES is a power of two, so chunk numbers and
   // entry indices reduce by truncation.
   localparam int TABLE_ENTRIES = 16;
   localparam int CHUNK_SHIFT   = 28;
   localparam int PID_BITS      = 8;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);

   // Operation codes
   localparam logic [1:0] FUNC_ALLOC = 2'd0;
   localparam logic [1:0] FUNC_FREE  = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;
   localparam logic [1:0] FUNC_WRITE = 2'd3;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] access_addr;
      logic [7:0]  access_len;
      logic [2:0]  beat_size_code;
      logic [7:0]  process_id;
      logic [3:0]  chunk_index;
      logic        write_perm;
   } req_type;

   typedef struct packed {
      logic [31:0] out_addr;
      logic        denied;
   } rsp_type;

   // Table update from the sequencer
   typedef struct packed {
      logic                set_valid;
      logic                clr_valid;
      logic [IDX_W-1:0]    idx;
      logic [PID_BITS-1:0] owner;
      logic                writable;
   } tbl_wr_type;

   // Registered table read result
   typedef struct packed {
      logic                valid;
      logic [PID_BITS-1:0] owner;
      logic                writable;
   } tbl_rd_type;

   // Chunk number of a byte address, reduced to the table width
   function automatic logic [IDX_W-1:0] chunk_of(input logic [31:0] addr);
      logic [31:0] shifted;
      shifted = addr >> CHUNK_SHIFT;
      return shifted[IDX_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ----- design/smcc_table.sv -----
`default_nettype none
module smcc_table (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire smcc_pkg::tbl_wr_type         wr,
   input  wire logic [smcc_pkg::IDX_W-1:0]   lk_idx,
   output logic                              lk_valid,
   input  wire logic                         rd_en,
   input  wire logic [smcc_pkg::IDX_W-1:0]   rd_idx,
   output smcc_pkg::tbl_rd_type              rd_data
);

   logic [smcc_pkg::TABLE_ENTRIES-1:0] valid_ff;
   logic [smcc_pkg::TABLE_ENTRIES-1:0] valid_in;
   logic [smcc_pkg::PID_BITS-1:0]      owner_mem [smcc_pkg::TABLE_ENTRIES];
   logic                               wperm_mem [smcc_pkg::TABLE_ENTRIES];
   smcc_pkg::tbl_rd_type               rd_ff;

   // valid marks: set on allocate, cleared on free
   always_comb begin
      valid_in = valid_ff;
      if (wr.set_valid) begin
         valid_in[wr.idx] = 1'b1;
      end else if (wr.clr_valid) begin
         valid_in[wr.idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign lk_valid = valid_ff[lk_idx];

   // owner / write permission store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr.set_valid) begin
         owner_mem[wr.idx] <= wr.owner;
         wperm_mem[wr.idx] <= wr.writable;
      end
      if (rd_en) begin
         rd_ff.valid    <= valid_ff[rd_idx];
         rd_ff.owner    <= owner_mem[rd_idx];
         rd_ff.writable <= wperm_mem[rd_idx];
      end
   end

   assign rd_data = rd_ff;

endmodule
`default_nettype wire

// ----- design/segment_mmu_chunk_checker.sv -----
`default_nettype none
// Segment permission checker. A request is taken when start is high and busy
// is low; busy then stays high until the cycle in which the single result is
// strobed out on rsp_strobe, which the receiver must take as it comes (there
// is no back-pressure). Allocate and free pass through the EXEC state to the result.
// A read or write check passes through SPAN, then WALK once for each table
// entry in the span's chunk range (1 to TABLE_ENTRIES), then FLUSH: the sequencer
// walks that range one entry per cycle through the table's registered read port.
// A check whose chunk range is empty checks nothing and goes from SPAN straight
// back to idle with its result.
// csr_write_data (the check enable) may only be written while busy is low.
module segment_mmu_chunk_checker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire smcc_pkg::req_type req_item,
   output logic                   rsp_strobe,
   output smcc_pkg::rsp_type      rsp_item,
   input  wire logic              csr_write_en,
   input  wire logic              csr_write_data
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EXEC  = 3'd1;
   localparam logic [2:0] ST_SPAN  = 3'd2;
   localparam logic [2:0] ST_WALK  = 3'd3;
   localparam logic [2:0] ST_FLUSH = 3'd4;

   localparam int SPAN_W = 15;

   logic [2:0]                    state_ff, state_in;
   smcc_pkg::req_type             req_ff, req_in;
   logic [smcc_pkg::IDX_W-1:0]    k_ff, k_in;
   logic [smcc_pkg::IDX_W-1:0]    last_ff, last_in;
   logic                          bad_ff, bad_in;
   logic                          pend_ff, pend_in;
   logic                          chk_en_ff;
   logic                          strobe_ff, strobe_in;
   smcc_pkg::rsp_type             rsp_ff, rsp_in;

   smcc_pkg::tbl_wr_type          tbl_wr;
   smcc_pkg::tbl_rd_type          tbl_rd;
   logic                          lk_valid;
   logic                          rd_en;
   logic [smcc_pkg::IDX_W-1:0]    ent_idx;
   logic [smcc_pkg::PID_BITS-1:0] pid;
   logic [SPAN_W-1:0]             span;
   logic [31:0]                   last_byte;
   logic [smcc_pkg::IDX_W-1:0]    first_chunk;
   logic [smcc_pkg::IDX_W-1:0]    last_chunk;
   logic                          need_write;
   logic                          bad_now;

   smcc_table u_table (
      .clock    (clock),
      .reset    (reset),
      .wr       (tbl_wr),
      .lk_idx   (ent_idx),
      .lk_valid (lk_valid),
      .rd_en    (rd_en),
      .rd_idx   (k_ff),
      .rd_data  (tbl_rd)
   );

   // operand shaping
   assign ent_idx     = smcc_pkg::IDX_W'(req_ff.chunk_index);
   assign pid         = smcc_pkg::PID_BITS'(req_ff.process_id);
   assign span        = SPAN_W'(req_ff.access_len) << req_ff.beat_size_code;
   assign last_byte   = req_ff.access_addr + 32'(span) - 32'd1;
   assign first_chunk = smcc_pkg::chunk_of(req_ff.access_addr);
   assign last_chunk  = smcc_pkg::chunk_of(last_byte);
   assign need_write  = (req_ff.func == smcc_pkg::FUNC_WRITE);

   // entry read last cycle fails the check
   assign bad_now = pend_ff && (!tbl_rd.valid || (tbl_rd.owner != pid) ||
                                (need_write && !tbl_rd.writable));

   assign busy = (state_ff != ST_IDLE);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      k_in      = k_ff;
      last_in   = last_ff;
      bad_in    = bad_ff | bad_now;
      pend_in   = 1'b0;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      rd_en     = 1'b0;
      tbl_wr    = '{set_valid: 1'b0, clr_valid: 1'b0, idx: ent_idx,
                    owner: pid, writable: req_ff.write_perm};
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_item;
               bad_in = 1'b0;
               if (req_item.func == smcc_pkg::FUNC_ALLOC ||
                   req_item.func == smcc_pkg::FUNC_FREE) begin
                  state_in = ST_EXEC;
               end else begin
                  state_in = ST_SPAN;
               end
            end
         end
         ST_EXEC: begin
            rsp_in.out_addr = '0;
            if (req_ff.func == smcc_pkg::FUNC_ALLOC) begin
               rsp_in.denied    = lk_valid;
               tbl_wr.set_valid = !lk_valid;
            end else begin
               rsp_in.denied    = !lk_valid;
               tbl_wr.clr_valid = lk_valid;
            end
            strobe_in = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_SPAN: begin
            k_in    = first_chunk;
            last_in = last_chunk;
            if (last_chunk < first_chunk) begin
               rsp_in.out_addr = req_ff.access_addr;
               rsp_in.denied   = 1'b0;
               strobe_in       = 1'b1;
               state_in        = ST_IDLE;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            rd_en   = 1'b1;
            pend_in = 1'b1;
            if (k_ff == last_ff) begin
               state_in = ST_FLUSH;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_FLUSH: begin
            rsp_in.out_addr = req_ff.access_addr;
            rsp_in.denied   = (bad_ff | bad_now) & chk_en_ff;
            strobe_in       = 1'b1;
            state_in        = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         pend_ff   <= 1'b0;
         strobe_ff <= 1'b0;
         chk_en_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pend_ff   <= pend_in;
         strobe_ff <= strobe_in;
         if (csr_write_en) begin
            chk_en_ff <= csr_write_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      k_ff    <= k_in;
      last_ff <= last_in;
      bad_ff  <= bad_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule
`default_nettype wire

// ----- tb/tb_segment_mmu_chunk_checker.sv -----
`default_nettype none
module tb_segment_mmu_chunk_checker;

   localparam int CLOCK_HALF   = 4;
   localparam int RESET_CYCLES = 9;
   localparam int PHASE_COUNT  = 5;
   localparam int PHASE_ITEMS  = 370;
   localparam int MAX_GAP      = 8;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int REPORT_MAX   = 10;

   // Shadow of the chunk table plus the queue of verdicts still to arrive
   class chunk_table_scoreboard;
      bit                            tbl_valid [smcc_pkg::TABLE_ENTRIES];
      logic [smcc_pkg::PID_BITS-1:0] tbl_owner [smcc_pkg::TABLE_ENTRIES];
      bit                            tbl_writable [smcc_pkg::TABLE_ENTRIES];
      bit                            check_on;
      smcc_pkg::rsp_type             pending_verdicts [$];
      int                            fail_count;

      function new();
         foreach (tbl_valid[k]) tbl_valid[k] = 1'b0;
         check_on   = 1'b0;
         fail_count = 0;
      endfunction

      // Work out the verdict of an accepted request and update the table
      function void note_request(smcc_pkg::req_type item);
         smcc_pkg::rsp_type             verdict;
         logic [smcc_pkg::IDX_W-1:0]    idx;
         logic [smcc_pkg::PID_BITS-1:0] pid;
         logic [31:0]                   span;
         logic [31:0]                   last_byte;
         logic [smcc_pkg::IDX_W-1:0]    lo_chunk;
         logic [smcc_pkg::IDX_W-1:0]    hi_chunk;
         bit                            bad;
         verdict = '0;
         idx     = item.chunk_index[smcc_pkg::IDX_W-1:0];
         pid     = item.process_id[smcc_pkg::PID_BITS-1:0];
         case (item.func)
            smcc_pkg::FUNC_ALLOC: begin
               if (tbl_valid[idx]) begin
                  verdict.denied = 1'b1;
               end else begin
                  tbl_valid[idx]    = 1'b1;
                  tbl_owner[idx]    = pid;
                  tbl_writable[idx] = item.write_perm;
               end
            end
            smcc_pkg::FUNC_FREE: begin
               if (!tbl_valid[idx]) verdict.denied = 1'b1;
               else tbl_valid[idx] = 1'b0;
            end
            default: begin
               verdict.out_addr = item.access_addr;
               span      = 32'(item.access_len) << item.beat_size_code;
               last_byte = item.access_addr + span - 32'd1;
               lo_chunk  = smcc_pkg::IDX_W'(item.access_addr >> smcc_pkg::CHUNK_SHIFT);
               hi_chunk  = smcc_pkg::IDX_W'(last_byte >> smcc_pkg::CHUNK_SHIFT);
               bad       = 1'b0;
               // an end chunk below the start chunk leaves nothing to check
               for (int k = 0; k < smcc_pkg::TABLE_ENTRIES; k++) begin
                  if (k >= lo_chunk && k <= hi_chunk) begin
                     if (!tbl_valid[k] || tbl_owner[k] != pid ||
                         (item.func == smcc_pkg::FUNC_WRITE && !tbl_writable[k]))
                        bad = 1'b1;
                  end
               end
               verdict.denied = bad & check_on;
            end
         endcase
         pending_verdicts.push_back(verdict);
      endfunction

      function void report(string msg);
         fail_count++;
         if (fail_count <= REPORT_MAX) $display("%s", msg);
      endfunction

      // Compare one strobed result with the oldest verdict
      function void check_result(smcc_pkg::rsp_type got);
         smcc_pkg::rsp_type want;
         if (pending_verdicts.size() == 0) begin
            report($sformatf("unexpected result: addr %h denied %b",
                             got.out_addr, got.denied));
            return;
         end
         want = pending_verdicts.pop_front();
         if (got.out_addr !== want.out_addr)
            report($sformatf("out_addr mismatch: expected %h actual %h",
                             want.out_addr, got.out_addr));
         if (got.denied !== want.denied)
            report($sformatf("denied mismatch (addr %h): expected %b actual %b",
                             want.out_addr, want.denied, got.denied));
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   smcc_pkg::req_type req_item = '0;
   logic              rsp_strobe;
   smcc_pkg::rsp_type rsp_item;
   logic              csr_write_en = 1'b0;
   logic              csr_write_data = 1'b0;

   chunk_table_scoreboard board;
   logic [7:0] pid_pool [4];
   int         cycle_count = 0;

   segment_mmu_chunk_checker u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_item       (req_item),
      .rsp_strobe     (rsp_strobe),
      .rsp_item       (rsp_item),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always #CLOCK_HALF clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Result monitor: values read here are the ones that close this cycle
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) board.check_result(rsp_item);
   end

   function automatic smcc_pkg::req_type make_req(logic [1:0] func, logic [31:0] addr,
                                                  logic [7:0] len, logic [2:0] code,
                                                  logic [7:0] pid, logic [3:0] idx,
                                                  logic wperm);
      smcc_pkg::req_type r;
      r.func           = func;
      r.access_addr    = addr;
      r.access_len     = len;
      r.beat_size_code = code;
      r.process_id     = pid;
      r.chunk_index    = idx;
      r.write_perm     = wperm;
      return r;
   endfunction

   // Mostly well-formed traffic: owner-matched checks inside live chunks,
   // boundary-straddling checks, table churn, plus fully random noise
   function automatic smcc_pkg::req_type make_random_request();
      smcc_pkg::req_type          r;
      int                         pick;
      logic [smcc_pkg::IDX_W-1:0] k;
      logic [31:0]                base;
      r = make_req(2'($urandom_range(0, 3)), $urandom, 8'($urandom_range(0, 255)),
                   3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                   4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      pick = $urandom_range(0, 99);
      k    = smcc_pkg::IDX_W'($urandom_range(0, smcc_pkg::TABLE_ENTRIES - 1));
      base = 32'(k) << smcc_pkg::CHUNK_SHIFT;
      if (pick < 20) begin
         r.func = smcc_pkg::FUNC_ALLOC;
         if ($urandom_range(0, 3) != 0)
            r.process_id = pid_pool[2'($urandom_range(0, 3))];
      end else if (pick < 35) begin
         r.func = smcc_pkg::FUNC_FREE;
      end else if (pick < 90) begin
         r.func = $urandom_range(0, 1) ? smcc_pkg::FUNC_WRITE : smcc_pkg::FUNC_READ;
         if (board.tbl_valid[k] && $urandom_range(0, 7) != 0)
            r.process_id = board.tbl_owner[k];
         else
            r.process_id = pid_pool[2'($urandom_range(0, 3))];
         if (pick < 75) begin
            r.access_addr[smcc_pkg::CHUNK_SHIFT +: smcc_pkg::IDX_W] = k;
            if ($urandom_range(0, 1)) r.access_len = 8'($urandom_range(0, 16));
         end else if ($urandom_range(0, 1)) begin
            r.access_addr = base + 32'($urandom_range(0, 64));
            if ($urandom_range(0, 2) == 0) r.access_len = '0;
         end else begin
            r.access_addr = base - 32'($urandom_range(1, 40000));
         end
      end
      return r;
   endfunction

   // One request transfer after a random gap
   task automatic send_request(input smcc_pkg::req_type item);
      int gap;
      gap = $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_item <= item;
      start    <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_request(item);
   endtask

   task automatic wait_drained();
      while (board.pending_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_check_enable(input logic value);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      board.check_on = value;
   endtask

   initial begin
      board = new();
      pid_pool[0] = 8'h00;
      pid_pool[1] = 8'hFF;
      pid_pool[2] = 8'($urandom_range(0, 255));
      pid_pool[3] = 8'($urandom_range(0, 255));
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_check_enable(1'b1);

      // Fill every entry once so no check ever reads an unwritten owner
      for (int k = 0; k < smcc_pkg::TABLE_ENTRIES; k++)
         send_request(make_req(smcc_pkg::FUNC_ALLOC, $urandom,
                               8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                               8'(k * 17), 4'(k), 1'(k)));

      // Directed corner cases
      send_request(make_req(smcc_pkg::FUNC_ALLOC, 32'hFFFF_FFFF, 8'hFF, 3'd7, 8'h33,
                            4'd3, 1'b0));
      send_request(make_req(smcc_pkg::FUNC_FREE,  32'h0, 8'h0, 3'd0, 8'h00, 4'd5, 1'b0));
      send_request(make_req(smcc_pkg::FUNC_FREE,  32'h0, 8'h0, 3'd0, 8'h00, 4'd5, 1'b1));
      send_request(make_req(smcc_pkg::FUNC_READ,  32'h2000_0100, 8'd4, 3'd2, 8'h22,
                            4'd0, 1'b0));
      send_request(make_req(smcc_pkg::FUNC_WRITE, 32'h2000_0100, 8'd4, 3'd2, 8'h22,
                            4'd0, 1'b0));
      send_request(make_req(smcc_pkg::FUNC_WRITE, 32'h3ABC_DEF0, 8'd8, 3'd3, 8'h33,
                            4'd0, 1'b0));
      send_request(make_req(smcc_pkg::FUNC_READ,  32'h3ABC_DEF0, 8'd8, 3'd3, 8'h34,
                            4'd0, 1'b0));
      send_request(make_req(smcc_pkg::FUNC_READ,  32'h5000_0000, 8'd1, 3'd0, 8'h55,
                            4'd0, 1'b0));
      // zero length at address zero spans the whole table
      send_request(make_req(smcc_pkg::FUNC_READ,  32'h0, 8'd0, 3'd0, 8'h00, 4'd0, 1'b0));
      // zero length on a chunk boundary checks nothing
      send_request(make_req(smcc_pkg::FUNC_WRITE, 32'h3000_0000, 8'd0, 3'd5, 8'hA7,
                            4'd0, 1'b0));
      // span past the top of memory wraps below the start chunk
      send_request(make_req(smcc_pkg::FUNC_READ,  32'hFFFF_FF00, 8'hFF, 3'd7, 8'h12,
                            4'd0, 1'b0));
      send_request(make_req(smcc_pkg::FUNC_READ,  32'h2FFF_FFF0, 8'hFF, 3'd7, 8'h22,
                            4'd0, 1'b0));
      send_request(make_req(smcc_pkg::FUNC_WRITE, 32'hFFFF_FFFF, 8'hFF, 3'd7, 8'hFF,
                            4'hF, 1'b1));
      send_request(make_req(smcc_pkg::FUNC_ALLOC, 32'h0, 8'h0, 3'd0, 8'hFF, 4'd5, 1'b1));

      // Random phases, toggling the check enable between them
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase > 0) begin
            start <= 1'b0;
            wait_drained();
            write_check_enable(1'((phase + 1) % 2));
         end
         repeat (PHASE_ITEMS) send_request(make_random_request());
      end

      start <= 1'b0;
      wait_drained();
      repeat (24) @(posedge clock);
      if (board.fail_count == 0 && board.pending_verdicts.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
`default_nettype wire
